// ===== hdl/cda_pkg.sv =====
// ----------------------------------------------------------------------------
// Calendar date adder package
// Opcodes, status codes, controller/datapath command and status groups, and
// the leap-year and month-length helpers shared by the datapath.
// ----------------------------------------------------------------------------
package cda_pkg;

    typedef enum logic [1:0] {
        OP_SET        = 2'd0,
        OP_ADD_DAYS   = 2'd1,
        OP_ADD_MONTHS = 2'd2,
        OP_ADD_YEARS  = 2'd3
    } t_op;

    localparam logic [1:0]  ST_OK       = 2'd0;
    localparam logic [1:0]  ST_BAD_DATE = 2'd1;
    localparam logic [1:0]  ST_RANGE    = 2'd2;

    localparam logic [15:0] RESET_YEAR  = 16'd2001;
    localparam logic [3:0]  RESET_MONTH = 4'd1;
    localparam logic [4:0]  RESET_DAY   = 5'd1;

    localparam logic [15:0] YEAR_MAX    = 16'hFFFF;
    localparam logic [3:0]  MONTH_JAN   = 4'd1;
    localparam logic [3:0]  MONTH_FEB   = 4'd2;
    localparam logic [3:0]  MONTH_MAR   = 4'd3;
    localparam logic [3:0]  MONTH_DEC   = 4'd12;
    localparam logic [4:0]  LEAP_DAY    = 5'd29;

    // y is a multiple of 25 exactly when y * inv(25) mod 2^16 <= floor(65535 / 25)
    localparam logic [15:0] INV25       = 16'd23593;
    localparam logic [15:0] DIV25_LIMIT = 16'd2621;
    // floor(t / 3) = (t * 43691) >> 17 for t below 2^15
    localparam logic [15:0] RECIP3      = 16'd43691;

    typedef struct packed {
        logic load;
        logic set_chk;
        logic day_step;
        logic mdiv;
        logic madd;
        logic yadd;
        logic fix;
        logic commit;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic n_zero;
        logic day_ovf;
        logic m_ovf;
        logic y_ovf;
    } t_stat;

    function automatic logic f_is_leap(input logic [15:0] y);
        logic [31:0] prod;
        logic        div25;
        prod  = 32'(y) * 32'(INV25);
        div25 = (prod[15:0] <= DIV25_LIMIT);
        // centuries count only when divisible by 400, i.e. also by 16
        return (y[1:0] == 2'd0) && (!div25 || (y[3:0] == 4'd0));
    endfunction

    function automatic logic [4:0] f_month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m) inside
            MONTH_FEB:                len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:  len = 5'd30;
            default:                  len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

// ===== hdl/cda_if.sv =====
// ----------------------------------------------------------------------------
// Calendar date adder channels
// Request channel (operation and operands) and response channel (date and
// status), each a valid/ready handshake.
// ----------------------------------------------------------------------------
interface cda_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [15:0] new_year;
    logic [3:0]  new_month;
    logic [4:0]  new_day;
    logic [15:0] amount;
    logic signed [15:0] year_delta;

    modport source (output valid, opcode, new_year, new_month, new_day, amount,
                    year_delta, input ready);
    modport sink   (input valid, opcode, new_year, new_month, new_day, amount,
                    year_delta, output ready);
endinterface

interface cda_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] cur_year;
    logic [3:0]  cur_month;
    logic [4:0]  cur_day;
    logic [1:0]  status;

    modport source (output valid, cur_year, cur_month, cur_day, status, input ready);
    modport sink   (input valid, cur_year, cur_month, cur_day, status, output ready);
endinterface

// ===== hdl/cda_ctrl.sv =====
// ----------------------------------------------------------------------------
// Calendar date adder controller
// Sequences one request through the datapath and owns both handshakes.
// ----------------------------------------------------------------------------
module cda_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  cda_pkg::t_stat i_stat,
    output cda_pkg::t_cmd  o_cmd
);
    import cda_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,
        S_DISP = 10'b00_0000_0010,
        S_SET  = 10'b00_0000_0100,
        S_DAYS = 10'b00_0000_1000,
        S_MDIV = 10'b00_0001_0000,
        S_MADD = 10'b00_0010_0000,
        S_YADD = 10'b00_0100_0000,
        S_LEAP = 10'b00_1000_0000,
        S_FIX  = 10'b01_0000_0000,
        S_DONE = 10'b10_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    t_cmd   cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_state  = S_DISP;
                end
            end
            S_DISP: begin
                unique case (i_stat.op)
                    OP_SET:        n_state = S_SET;
                    OP_ADD_DAYS:   n_state = S_DAYS;
                    OP_ADD_MONTHS: n_state = S_MDIV;
                    OP_ADD_YEARS:  n_state = S_YADD;
                    default:       n_state = S_IDLE;
                endcase
            end
            S_SET: begin
                cmd.set_chk = 1'b1;
                n_state     = S_DONE;
            end
            S_DAYS: begin
                // walk one month per cycle until the remaining count is spent or the year overflows
                if (i_stat.n_zero) begin
                    n_state = S_DONE;
                end else begin
                    cmd.day_step = 1'b1;
                    if (i_stat.day_ovf) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_MDIV: begin
                cmd.mdiv = 1'b1;
                n_state  = S_MADD;
            end
            S_MADD: begin
                cmd.madd = 1'b1;
                n_state  = i_stat.m_ovf ? S_DONE : S_LEAP;
            end
            S_YADD: begin
                cmd.yadd = 1'b1;
                n_state  = i_stat.y_ovf ? S_DONE : S_LEAP;
            end
            S_LEAP: begin
                // wait here so the leap flag follows the new year
                n_state = S_FIX;
            end
            S_FIX: begin
                cmd.fix = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    cmd.commit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule

// ===== hdl/cda_datapath.sv =====
// ----------------------------------------------------------------------------
// Calendar date adder datapath
// Stored date, working date, day counter, month divider and leap flag.
// ----------------------------------------------------------------------------
module cda_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cda_pkg::t_cmd       i_cmd,
    output cda_pkg::t_stat      o_stat,
    input  cda_pkg::t_op        i_opcode,
    input  logic [15:0]         i_new_year,
    input  logic [3:0]          i_new_month,
    input  logic [4:0]          i_new_day,
    input  logic [15:0]         i_amount,
    input  logic signed [15:0]  i_year_delta,
    output logic [15:0]         o_cur_year,
    output logic [3:0]          o_cur_month,
    output logic [4:0]          o_cur_day,
    output logic [1:0]          o_status
);
    import cda_pkg::*;

    // stored date
    logic [15:0] r_year;
    logic [3:0]  r_month;
    logic [4:0]  r_day;
    logic [1:0]  r_ostat;

    // working copy
    t_op         r_op;
    logic [15:0] r_wy;
    logic [3:0]  r_wm;
    logic [4:0]  r_wd;
    logic [15:0] r_n;
    logic [16:0] r_total;
    logic [13:0] r_q;
    logic [3:0]  r_nm;
    logic [4:0]  r_nd;
    logic [15:0] r_delta;
    logic [1:0]  r_status;
    logic        r_leap;

    logic [4:0]  len;
    logic [16:0] day_sum;
    logic        day_over;
    logic [16:0] day_rem;
    logic        day_ovf;
    logic [30:0] mul_prod;
    logic [16:0] m_sum;
    logic [16:0] q12;
    logic [16:0] m_rem;
    logic [17:0] y_sum;
    logic        y_ovf;
    logic        set_ok;

    assign len      = f_month_len(r_wm, r_leap);
    assign day_sum  = {12'd0, r_wd} + {1'b0, r_n};
    assign day_over = (day_sum > {12'd0, len});
    assign day_rem  = day_sum - {12'd0, len} - 17'd1;
    assign day_ovf  = (r_n != 16'd0) && day_over && (r_wm >= MONTH_DEC) && (r_wy == YEAR_MAX);

    assign mul_prod = 31'(r_total[16:2]) * 31'(RECIP3);
    assign m_sum    = {1'b0, r_wy} + {3'd0, r_q};
    assign q12      = ({3'd0, r_q} << 3) + ({3'd0, r_q} << 2);
    assign m_rem    = r_total - q12;

    assign y_sum    = {2'b00, r_wy} + {{2{r_delta[15]}}, r_delta};
    assign y_ovf    = y_sum[17] || y_sum[16];

    assign set_ok   = (r_nm >= MONTH_JAN) && (r_nm <= MONTH_DEC) && (r_nd != 5'd0)
                   && (r_nd <= f_month_len(r_nm, r_leap));

    assign o_stat.op      = r_op;
    assign o_stat.n_zero  = (r_n == 16'd0);
    assign o_stat.day_ovf = day_ovf;
    assign o_stat.m_ovf   = m_sum[16];
    assign o_stat.y_ovf   = y_ovf;

    always_ff @(posedge i_clk) begin
        r_leap <= f_is_leap(r_wy);
        if (i_cmd.load) begin
            r_op     <= i_opcode;
            r_wy     <= (i_opcode == OP_SET) ? i_new_year : r_year;
            r_wm     <= r_month;
            r_wd     <= r_day;
            r_n      <= i_amount;
            r_total  <= {13'd0, r_month - 4'd1} + {1'b0, i_amount};
            r_nm     <= i_new_month;
            r_nd     <= i_new_day;
            r_delta  <= i_year_delta;
            r_status <= ST_OK;
        end
        if (i_cmd.set_chk) begin
            if (set_ok) begin
                r_wm <= r_nm;
                r_wd <= r_nd;
            end else begin
                r_status <= ST_BAD_DATE;
            end
        end
        if (i_cmd.day_step) begin
            if (day_over) begin
                r_n  <= day_rem[15:0];
                r_wd <= 5'd1;
                if (r_wm >= MONTH_DEC) begin
                    r_wm <= MONTH_JAN;
                    if (r_wy == YEAR_MAX) begin
                        r_status <= ST_RANGE;
                    end else begin
                        r_wy <= r_wy + 16'd1;
                    end
                end else begin
                    r_wm <= r_wm + 4'd1;
                end
            end else begin
                r_wd <= day_sum[4:0];
                r_n  <= 16'd0;
            end
        end
        if (i_cmd.mdiv) begin
            r_q <= mul_prod[30:17];
        end
        if (i_cmd.madd) begin
            if (m_sum[16]) begin
                r_status <= ST_RANGE;
            end else begin
                r_wy <= m_sum[15:0];
                r_wm <= m_rem[3:0] + 4'd1;
            end
        end
        if (i_cmd.yadd) begin
            if (y_ovf) begin
                r_status <= ST_RANGE;
            end else begin
                r_wy <= y_sum[15:0];
            end
        end
        if (i_cmd.fix) begin
            if (r_op == OP_ADD_MONTHS) begin
                // clamp the day to the new month
                if (r_wd > len) begin
                    r_wd <= len;
                end
            end else if ((r_wm == MONTH_FEB) && (r_wd == LEAP_DAY) && !r_leap) begin
                r_wm <= MONTH_MAR;
                r_wd <= 5'd1;
            end
        end
        if (i_cmd.commit) begin
            r_ostat <= r_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_year  <= RESET_YEAR;
            r_month <= RESET_MONTH;
            r_day   <= RESET_DAY;
        end else if (i_cmd.commit && (r_status == ST_OK)) begin
            r_year  <= r_wy;
            r_month <= r_wm;
            r_day   <= r_wd;
        end
    end

    assign o_cur_year  = r_year;
    assign o_cur_month = r_month;
    assign o_cur_day   = r_day;
    assign o_status    = r_ostat;

endmodule

// ===== hdl/calendar_date_adder.sv =====
// ----------------------------------------------------------------------------
// Calendar date adder
// Holds one Gregorian date and applies set / add days / add months / add
// years requests to it, answering each with the stored date and a status.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one request (opcode and operands); o_rsp returns exactly
//   one response per request: the stored date after the request and a
//   status (ok, invalid date refused, year out of range refused). A refused
//   request leaves the date unchanged.
//   One request is in work at a time. After a dispatch state, set date
//   runs a check state; add years adds the delta and add months divides
//   and adds, each then waiting for the leap flag and fixing the day unless
//   the year is out of range; add days walks the date one month per cycle.
//   Every request ends in a done state that commits its response. The next
//   request is taken no earlier than the edge at which the current response
//   could first be taken, so no request is taken before the response to the
//   last one is committed.
//   i_req.ready is high only while no request is in work. A response waits
//   in the output register while o_rsp.ready is low; a new request may be
//   accepted meanwhile and is held at its end until the response is taken.
//   Reset (synchronous, active low) sets the date to 1 January 2001 and
//   drops any pending response.
// ----------------------------------------------------------------------------
module calendar_date_adder (
    input  logic     i_clk,
    input  logic     i_rst_n,
    cda_req_if.sink  i_req,
    cda_rsp_if.source o_rsp
);
    import cda_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    cda_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    cda_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_opcode     (t_op'(i_req.opcode)),
        .i_new_year   (i_req.new_year),
        .i_new_month  (i_req.new_month),
        .i_new_day    (i_req.new_day),
        .i_amount     (i_req.amount),
        .i_year_delta (i_req.year_delta),
        .o_cur_year   (o_rsp.cur_year),
        .o_cur_month  (o_rsp.cur_month),
        .o_cur_day    (o_rsp.cur_day),
        .o_status     (o_rsp.status)
    );

    a_commit_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |-> (!o_rsp.valid || o_rsp.ready))
        else $error("response committed over a pending response");

    a_commit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |=> o_rsp.valid)
        else $error("committed response not presented");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("second request taken while one is in work");

    a_month_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> ((o_rsp.cur_month >= MONTH_JAN) && (o_rsp.cur_month <= MONTH_DEC)
                         && (o_rsp.cur_day != 5'd0)
                         && (o_rsp.status <= ST_RANGE)))
        else $error("stored date or status out of range");

endmodule
